// ----- rtl/core/kwm_pkg.sv -----
// package for the k-way sorted merge unit
// sizes, cell row entry and command types; no dependencies
`default_nettype none

package kwm_pkg;

  localparam int NUM_LANES = 8;
  localparam int VALUE_W   = 32;
  localparam int LANE_W    = 3;
  localparam int CFG_W     = 4;
  localparam int CNT_W     = $clog2(NUM_LANES + 1);

  // one held head in the sorted cell row
  typedef struct packed {
    logic                      valid;
    logic signed [VALUE_W-1:0] value;
    logic [LANE_W-1:0]         lane;
  } entry_t;

  // operation applied to every cell in the same cycle
  typedef enum logic [1:0] {
    OP_NOP,
    OP_INSERT,
    OP_POP,
    OP_CLEAR
  } op_e;

  typedef struct packed {
    op_e                       op;
    logic signed [VALUE_W-1:0] value;
    logic [LANE_W-1:0]         lane;
  } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/core/kwm_if.sv -----
// valid/ready channel interfaces of the k-way sorted merge unit
// depends on kwm_pkg for field widths
`default_nettype none

// input items: one stream element or exhausted mark per beat
interface kwm_item_if;
  import kwm_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [LANE_W-1:0]         lane;
  logic signed [VALUE_W-1:0] value;
  logic                      present;
  modport source (output valid, lane, value, present, input ready);
  modport sink   (input valid, lane, value, present, output ready);
endinterface

// merged output: one element or end marker per beat
interface kwm_merged_if;
  import kwm_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] merged_value;
  logic [LANE_W-1:0]         source_lane;
  logic                      is_end;
  modport source (output valid, merged_value, source_lane, is_end, input ready);
  modport sink   (input valid, merged_value, source_lane, is_end, output ready);
endinterface

// configuration write channel for lanes_in_use
interface kwm_cfg_if;
  import kwm_pkg::*;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] lanes_in_use;
  modport source (output valid, lanes_in_use, input ready);
  modport sink   (input valid, lanes_in_use, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/kwm_cell.sv -----
// one cell of the sorted head row: holds a single (value, lane) entry
// depends on kwm_pkg for entry and command types
`default_nettype none

module kwm_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  kwm_pkg::cmd_t   cmd_i,
  input  kwm_pkg::entry_t left_i,
  input  logic            left_gt_i,
  input  kwm_pkg::entry_t right_i,
  output kwm_pkg::entry_t entry_o,
  output logic            gt_o
);
  import kwm_pkg::*;

  logic                      valid_q, valid_d;
  logic signed [VALUE_W-1:0] value_q, value_d;
  logic [LANE_W-1:0]         lane_q, lane_d;

  // empty cell or larger entry orders after the new item, lane breaks ties
  assign gt_o = !valid_q || (value_q > cmd_i.value) ||
                ((value_q == cmd_i.value) && (lane_q > cmd_i.lane));

  assign entry_o = '{valid: valid_q, value: value_q, lane: lane_q};

  // insert shifts larger entries right, pop shifts everything left, clear empties the cell
  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    lane_d  = lane_q;
    unique case (cmd_i.op)
      OP_INSERT: begin
        if (gt_o && left_gt_i) begin
          valid_d = left_i.valid;
          value_d = left_i.value;
          lane_d  = left_i.lane;
        end else if (gt_o) begin
          valid_d = 1'b1;
          value_d = cmd_i.value;
          lane_d  = cmd_i.lane;
        end
      end
      OP_POP: begin
        valid_d = right_i.valid;
        value_d = right_i.value;
        lane_d  = right_i.lane;
      end
      OP_CLEAR: valid_d = 1'b0;
      default:  valid_d = valid_q;
    endcase
  end

  // occupancy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // entry payload
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    lane_q  <= lane_d;
  end

endmodule

`default_nettype wire

// ----- rtl/core/kwm_chain.sv -----
// row of kwm_cell instances kept in ascending (value, lane) order
// depends on kwm_pkg and kwm_cell
`default_nettype none

module kwm_chain (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  kwm_pkg::cmd_t   cmd_i,
  output kwm_pkg::entry_t entries_o [kwm_pkg::NUM_LANES]
);
  import kwm_pkg::*;

  entry_t entry   [NUM_LANES];
  logic   gt      [NUM_LANES];
  entry_t left_e  [NUM_LANES];
  logic   left_gt [NUM_LANES];
  entry_t right_e [NUM_LANES];

  // neighbor links, empty at both ends of the row
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      left_e[i]  = (i == 0) ? '0 : entry[(i == 0) ? 0 : i - 1];
      left_gt[i] = (i == 0) ? 1'b0 : gt[(i == 0) ? 0 : i - 1];
      right_e[i] = (i == NUM_LANES - 1) ? '0 : entry[(i == NUM_LANES - 1) ? i : i + 1];
    end
  end

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_cell
    kwm_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cmd_i),
      .left_i    (left_e[g]),
      .left_gt_i (left_gt[g]),
      .right_i   (right_e[g]),
      .entry_o   (entry[g]),
      .gt_o      (gt[g])
    );
    assign entries_o[g] = entry[g];
  end

endmodule

`default_nettype wire

// ----- rtl/core/k_way_sorted_merge_unit.sv -----
// k-way sorted merge unit, top level
// depends on kwm_pkg, the channel interfaces in kwm_if and kwm_chain
//
// usage:
//   item_i   : input beats (lane, value, present). while loading, one beat per
//              lane in use is taken, in any order; repeated or unused lanes
//              are dropped. while merging, only the lane named by the last
//              output beat is taken, beats for other lanes are dropped.
//   merged_o : ascending output beats (merged_value, source_lane, is_end);
//              ties go to the lower lane. an end beat (is_end = 1, other
//              fields 0) follows once every lane is exhausted, and loading
//              starts over.
//   cfg_i    : writes lanes_in_use (0 acts as 1, above 8 acts as 8) and
//              restarts loading; write it only while the block is idle.
// order: the beat that completes loading or refills the awaited lane moves
//   the block to its pop state, whose pop fills the output register; while
//   merging, a new head is inserted in the sorted row, then its minimum popped.
// stall: the result waits in the output register; the next input beat is
//   still taken and the following pop waits until the output is free.
// reset: lanes_in_use is 8, the cell row is empty and loading begins; no
//   clearing pass is needed.
`default_nettype none

module k_way_sorted_merge_unit (
  input  logic  clk_i,
  input  logic  rst_ni,
  kwm_item_if.sink     item_i,
  kwm_merged_if.source merged_o,
  kwm_cfg_if.sink      cfg_i
);
  import kwm_pkg::*;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_WAIT,
    ST_POP
  } state_e;

  state_e                    state_q, state_d;
  logic [CFG_W-1:0]          lanes_q, lanes_d;
  logic [NUM_LANES-1:0]      loaded_q, loaded_d;
  logic [CNT_W-1:0]          count_q, count_d;
  logic [LANE_W-1:0]         awaited_q, awaited_d;
  logic                      out_valid_q, out_valid_d;
  logic signed [VALUE_W-1:0] out_value_q, out_value_d;
  logic [LANE_W-1:0]         out_lane_q, out_lane_d;
  logic                      out_end_q, out_end_d;

  logic                 in_fire;
  logic                 cfg_fire;
  logic                 pop_fire;
  logic [CNT_W-1:0]     active;
  logic [CNT_W-1:0]     count_inc;
  cmd_t                 cmd;
  entry_t               entries [NUM_LANES];
  entry_t               head;
  logic [NUM_LANES-1:0] held_vec;

  // handshakes
  assign item_i.ready = (state_q == ST_LOAD) || (state_q == ST_WAIT);
  assign cfg_i.ready  = 1'b1;
  assign in_fire      = item_i.valid && item_i.ready;
  assign cfg_fire     = cfg_i.valid && cfg_i.ready;
  assign pop_fire     = (state_q == ST_POP) && (!out_valid_q || merged_o.ready);

  assign merged_o.valid        = out_valid_q;
  assign merged_o.merged_value = out_value_q;
  assign merged_o.source_lane  = out_lane_q;
  assign merged_o.is_end       = out_end_q;

  // clamp lanes_in_use to 1..NUM_LANES
  always_comb begin
    if (lanes_q == '0) begin
      active = CNT_W'(1);
    end else if (int'(lanes_q) > NUM_LANES) begin
      active = CNT_W'(NUM_LANES);
    end else begin
      active = CNT_W'(lanes_q);
    end
  end

  assign count_inc = CNT_W'(count_q + 1'b1);
  assign head      = entries[0];

  // sorted head row
  kwm_chain u_chain (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .entries_o (entries)
  );

  // sequencing: load heads, then pop / refill until the row runs empty
  always_comb begin
    state_d     = state_q;
    lanes_d     = lanes_q;
    loaded_d    = loaded_q;
    count_d     = count_q;
    awaited_d   = awaited_q;
    out_valid_d = out_valid_q;
    out_value_d = out_value_q;
    out_lane_d  = out_lane_q;
    out_end_d   = out_end_q;
    cmd         = '{op: OP_NOP, value: item_i.value, lane: item_i.lane};

    if (out_valid_q && merged_o.ready) begin
      out_valid_d = 1'b0;
    end

    if (cfg_fire) begin
      lanes_d   = cfg_i.lanes_in_use;
      loaded_d  = '0;
      count_d   = '0;
      awaited_d = '0;
      state_d   = ST_LOAD;
      cmd.op    = OP_CLEAR;
    end else begin
      unique case (state_q)
        ST_LOAD: begin
          if (in_fire && ({1'b0, item_i.lane} < {1'b0, active}) &&
              !loaded_q[item_i.lane]) begin
            loaded_d[item_i.lane] = 1'b1;
            count_d               = count_inc;
            if (item_i.present) begin
              cmd.op = OP_INSERT;
            end
            if (count_inc == active) begin
              state_d = ST_POP;
            end
          end
        end
        ST_WAIT: begin
          if (in_fire && (item_i.lane == awaited_q)) begin
            if (item_i.present) begin
              cmd.op = OP_INSERT;
            end
            state_d = ST_POP;
          end
        end
        ST_POP: begin
          if (pop_fire) begin
            out_valid_d = 1'b1;
            if (head.valid) begin
              out_value_d = head.value;
              out_lane_d  = head.lane;
              out_end_d   = 1'b0;
              awaited_d   = head.lane;
              cmd.op      = OP_POP;
              state_d     = ST_WAIT;
            end else begin
              out_value_d = '0;
              out_lane_d  = '0;
              out_end_d   = 1'b1;
              loaded_d    = '0;
              count_d     = '0;
              awaited_d   = '0;
              state_d     = ST_LOAD;
            end
          end
        end
        default: state_d = ST_LOAD;
      endcase
    end
  end

  // state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      lanes_q     <= CFG_W'(NUM_LANES);
      loaded_q    <= '0;
      count_q     <= '0;
      awaited_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lanes_q     <= lanes_d;
      loaded_q    <= loaded_d;
      count_q     <= count_d;
      awaited_q   <= awaited_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output beat payload
  always_ff @(posedge clk_i) begin
    out_value_q <= out_value_d;
    out_lane_q  <= out_lane_d;
    out_end_q   <= out_end_d;
  end

  // occupancy of the cell row
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      held_vec[i] = entries[i].valid;
    end
  end

`ifndef SYNTHESIS
  // the row stays packed toward cell 0
  a_row_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_vec & NUM_LANES'(held_vec + 1'b1)) == '0)
    else $error("cell row has a gap");

  // never more held heads than lanes loaded
  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(held_vec) <= int'(count_q))
    else $error("more held heads than loaded lanes");

  // a popped element names the lane awaited next
  a_awaited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_fire && head.valid && !cfg_fire) |=>
      (awaited_q == out_lane_q) && (state_q == ST_WAIT) && !out_end_q)
    else $error("awaited lane does not match popped lane");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/kwm_merge_checker.sv -----
`timescale 1ns / 1ps
// scoreboard for the k-way sorted merge unit: watches item, merged and cfg beats
// keeps its own copy of the lane heads and predicts each merged beat; needs kwm_pkg, kwm_if

module kwm_merge_checker (
  input  logic  clk_i,
  input  logic  rst_ni,
  kwm_item_if   item_i,
  kwm_merged_if merged_i,
  kwm_cfg_if    cfg_i,
  output int    pending_o,
  output int    fail_count_o
);
  import kwm_pkg::*;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [LANE_W-1:0]         lane;
    logic                      is_end;
  } merged_beat_t;

  localparam int MAX_PRINTED = 100;

  logic [CFG_W-1:0]          lanes_reg;
  logic signed [VALUE_W-1:0] head_val    [NUM_LANES];
  logic                      head_held   [NUM_LANES];
  logic                      head_loaded [NUM_LANES];
  logic                      merging;
  logic [LANE_W-1:0]         awaited;
  int                        loaded_n;
  merged_beat_t              merge_exp_q [$];
  int                        mismatch_n = 0;

  assign fail_count_o = mismatch_n;

  // one printed line per mismatch, output kept bounded
  task automatic report(input string msg);
    mismatch_n++;
    if (mismatch_n <= MAX_PRINTED) begin
      $display("[%0t] merge check: %s", $time, msg);
    end
  endtask

  // register value 0 acts as one lane, anything above the lane count as all lanes
  function automatic int lanes_active();
    if (lanes_reg == '0) return 1;
    if (lanes_reg > NUM_LANES) return NUM_LANES;
    return int'(lanes_reg);
  endfunction

  task automatic restart_loading();
    for (int i = 0; i < NUM_LANES; i++) begin
      head_held[i]   = 1'b0;
      head_loaded[i] = 1'b0;
    end
    merging  = 1'b0;
    awaited  = '0;
    loaded_n = 0;
  endtask

  // smallest held head, lower lane on ties; end marker once nothing is held
  task automatic pop_minimum();
    int           best;
    merged_beat_t beat;
    best = -1;
    for (int i = 0; i < NUM_LANES; i++) begin
      if (head_held[i] && (best < 0 || head_val[i] < head_val[best])) best = i;
    end
    if (best < 0) begin
      beat.value  = '0;
      beat.lane   = '0;
      beat.is_end = 1'b1;
      restart_loading();
    end else begin
      beat.value      = head_val[best];
      beat.lane       = LANE_W'(best);
      beat.is_end     = 1'b0;
      head_held[best] = 1'b0;
      awaited         = LANE_W'(best);
      merging         = 1'b1;
    end
    merge_exp_q.push_back(beat);
  endtask

  // unused, repeated or not-awaited lanes fall through without a result
  task automatic take_item(input logic [LANE_W-1:0] lane,
                           input logic signed [VALUE_W-1:0] value,
                           input logic present);
    if (!merging) begin
      if (int'(lane) >= lanes_active() || head_loaded[lane]) return;
      head_loaded[lane] = 1'b1;
      head_held[lane]   = present;
      if (present) head_val[lane] = value;
      loaded_n++;
      if (loaded_n == lanes_active()) pop_minimum();
    end else if (lane == awaited) begin
      head_held[lane] = present;
      if (present) head_val[lane] = value;
      pop_minimum();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    merged_beat_t want;
    if (!rst_ni) begin
      lanes_reg = CFG_W'(NUM_LANES);
      restart_loading();
      merge_exp_q.delete();
      pending_o <= 0;
    end else begin
      // output beat first: a beat taken at this edge cannot answer before the next one
      if (merged_i.valid && merged_i.ready) begin
        if (merge_exp_q.size() == 0) begin
          report($sformatf("unexpected beat value %0d lane %0d end %0b",
                           merged_i.merged_value, merged_i.source_lane, merged_i.is_end));
        end else begin
          want = merge_exp_q.pop_front();
          if (merged_i.is_end !== want.is_end)
            report($sformatf("is_end got %0b expected %0b", merged_i.is_end, want.is_end));
          if (merged_i.merged_value !== want.value)
            report($sformatf("merged_value got %0d expected %0d",
                             merged_i.merged_value, want.value));
          if (merged_i.source_lane !== want.lane)
            report($sformatf("source_lane got %0d expected %0d",
                             merged_i.source_lane, want.lane));
        end
      end
      // register write restarts loading
      if (cfg_i.valid && cfg_i.ready) begin
        lanes_reg = cfg_i.lanes_in_use;
        restart_loading();
      end
      if (item_i.valid && item_i.ready) begin
        take_item(item_i.lane, item_i.value, item_i.present);
      end
      pending_o <= merge_exp_q.size();
    end
  end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// top of the k-way sorted merge testbench: clock, reset, stream stimulus and verdict
// depends on kwm_pkg, kwm_if, k_way_sorted_merge_unit and kwm_merge_checker

module tb_top;
  import kwm_pkg::*;

  localparam int     CLK_PERIOD    = 12;
  localparam int     MAX_GAP       = 17;
  localparam int     MAX_LEN       = 12;
  localparam int     ITEM_TARGET   = 1500;
  localparam int     SETTLE_CYCLES = 4;
  localparam int     DRAIN_CYCLES  = 8;
  localparam longint RUN_LIMIT_NS  = 10_000_000;

  localparam logic signed [VALUE_W-1:0] VMAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] VMIN = {1'b1, {(VALUE_W-1){1'b0}}};

  logic clk = 1'b0;
  logic rst_n;
  int   pending_n;
  int   fail_n;

  kwm_item_if   item_bus ();
  kwm_merged_if merged_bus ();
  kwm_cfg_if    cfg_bus ();

  k_way_sorted_merge_unit dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .item_i   (item_bus),
    .merged_o (merged_bus),
    .cfg_i    (cfg_bus)
  );

  kwm_merge_checker u_merge_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .item_i       (item_bus),
    .merged_i     (merged_bus),
    .cfg_i        (cfg_bus),
    .pending_o    (pending_n),
    .fail_count_o (fail_n)
  );

  // streams of the current merge set and how far each has been fed
  logic signed [VALUE_W-1:0] stream_val [NUM_LANES][MAX_LEN];
  int                        stream_len [NUM_LANES];
  int                        lane_pos   [NUM_LANES];
  logic                      lane_live  [NUM_LANES];
  logic signed [VALUE_W-1:0] lane_head  [NUM_LANES];
  int                        active_n;
  int                        items_sent;
  bit                        src_no_idle;
  bit                        sink_no_idle;

  always #(CLK_PERIOD / 2) clk = ~clk;

  // hard stop in case the block hangs
  initial begin
    #(RUN_LIMIT_NS);
    $display("Regression FAIL");
    $finish;
  end

  // result side: random stall before each beat, with runs of no stall
  initial begin
    int stall;
    merged_bus.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) sink_no_idle = !sink_no_idle;
      stall = sink_no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        merged_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      merged_bus.ready <= 1'b1;
      do @(posedge clk); while (!merged_bus.valid);
    end
  end

  function automatic logic signed [VALUE_W-1:0] corner_value(input int idx);
    case (idx)
      0:       return VMIN;
      1:       return VMIN + 1;
      2:       return -1;
      3:       return 0;
      4:       return 1;
      5:       return VMAX - 1;
      default: return VMAX;
    endcase
  endfunction

  // one item beat after a random gap; returns at the edge that takes it
  task automatic send_beat(input logic [LANE_W-1:0] lane,
                           input logic signed [VALUE_W-1:0] value,
                           input logic present);
    int gap;
    gap = src_no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      item_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_bus.valid   <= 1'b1;
    item_bus.lane    <= lane;
    item_bus.value   <= value;
    item_bus.present <= present;
    do @(posedge clk); while (!item_bus.ready);
  endtask

  // register write once every result is out and the block has settled
  task automatic write_lanes(input logic [CFG_W-1:0] lanes);
    item_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_n != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_bus.valid        <= 1'b1;
    cfg_bus.lanes_in_use <= lanes;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    active_n = (lanes == 0) ? 1 : (lanes > NUM_LANES) ? NUM_LANES : int'(lanes);
  endtask

  task automatic clear_streams();
    for (int l = 0; l < NUM_LANES; l++) begin
      stream_len[l] = 0;
      for (int k = 0; k < MAX_LEN; k++) stream_val[l][k] = '0;
    end
  endtask

  // narrow sorted (many ties), wide sorted, corner values, or unsorted
  task automatic fill_streams();
    int     shape;
    int     max_len;
    int     corner;
    longint cur;
    shape   = $urandom_range(0, 9);
    max_len = ($urandom_range(0, 7) == 0) ? MAX_LEN : 4;
    for (int l = 0; l < NUM_LANES; l++) begin
      stream_len[l] = $urandom_range(0, max_len);
      corner        = $urandom_range(0, 6);
      cur = (shape < 3) ? longint'($urandom_range(0, 6)) - 3 : longint'($signed($urandom()));
      for (int k = 0; k < MAX_LEN; k++) begin
        if (shape == 9) begin
          stream_val[l][k] = $urandom();
        end else if (shape >= 7) begin
          stream_val[l][k] = corner_value(corner);
          if (corner < 6) corner += $urandom_range(0, 1);
        end else begin
          stream_val[l][k] = cur[VALUE_W-1:0];
          cur += (shape < 3) ? $urandom_range(0, 2) : $urandom_range(0, 1 << 27);
          if (cur > longint'(VMAX)) cur = longint'(VMAX);
        end
      end
    end
  endtask

  // next element of a lane, or its exhausted mark
  task automatic feed_lane(input int l);
    if (lane_pos[l] < stream_len[l]) begin
      lane_head[l] = stream_val[l][lane_pos[l]];
      lane_live[l] = 1'b1;
      lane_pos[l]++;
      send_beat(LANE_W'(l), lane_head[l], 1'b1);
    end else begin
      lane_live[l] = 1'b0;
      send_beat(LANE_W'(l), $urandom(), 1'b0);
    end
    items_sent++;
  endtask

  // one full merge: load every lane in use, then refill whichever lane was popped
  task automatic run_merge_set(input int noise_pct);
    int order [NUM_LANES];
    int j;
    int tmp;
    int best;
    bit done;
    for (int l = 0; l < NUM_LANES; l++) begin
      order[l]     = l;
      lane_pos[l]  = 0;
      lane_live[l] = 1'b0;
      lane_head[l] = '0;
    end
    for (int l = active_n - 1; l > 0; l--) begin
      j        = $urandom_range(0, l);
      tmp      = order[l];
      order[l] = order[j];
      order[j] = tmp;
    end
    // loading, with repeated or unused lanes mixed in as noise
    for (int n = 0; n < active_n; n++) begin
      if ($urandom_range(1, 100) <= noise_pct) begin
        if (n > 0 && (active_n == NUM_LANES || $urandom_range(0, 1) == 1))
          send_beat(LANE_W'(order[$urandom_range(0, n - 1)]), $urandom(),
                    1'($urandom_range(0, 1)));
        else if (active_n < NUM_LANES)
          send_beat(LANE_W'($urandom_range(active_n, NUM_LANES - 1)), $urandom(),
                    1'($urandom_range(0, 1)));
      end
      feed_lane(order[n]);
    end
    // merging: the popped lane is the one the block waits for
    done = 1'b0;
    while (!done) begin
      best = -1;
      for (int l = 0; l < NUM_LANES; l++) begin
        if (lane_live[l] && (best < 0 || lane_head[l] < lane_head[best])) best = l;
      end
      if (best < 0) begin
        done = 1'b1;
      end else begin
        lane_live[best] = 1'b0;
        if ($urandom_range(1, 100) <= noise_pct) begin
          j = $urandom_range(0, NUM_LANES - 2);
          if (j >= best) j++;
          send_beat(LANE_W'(j), $urandom(), 1'($urandom_range(0, 1)));
        end
        feed_lane(best);
      end
    end
  endtask

  initial begin
    rst_n                <= 1'b0;
    item_bus.valid       <= 1'b0;
    item_bus.lane        <= '0;
    item_bus.value       <= '0;
    item_bus.present     <= 1'b0;
    cfg_bus.valid        <= 1'b0;
    cfg_bus.lanes_in_use <= '0;
    src_no_idle  = 1'b0;
    items_sent   = 0;
    active_n     = NUM_LANES;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // register at its reset value: eight lanes, only the top lane carries data
    clear_streams();
    stream_len[7]    = 1;
    stream_val[7][0] = VMAX;
    run_merge_set(0);

    // zero acts as a single lane; unused and wrong lanes are dropped
    write_lanes(0);
    clear_streams();
    stream_len[0]    = 2;
    stream_val[0][0] = VMIN;
    stream_val[0][1] = 0;
    run_merge_set(100);

    // equal heads: lower lane goes first; repeated lanes dropped while loading
    write_lanes(2);
    clear_streams();
    stream_len[0]    = 1;
    stream_val[0][0] = 5;
    stream_len[1]    = 1;
    stream_val[1][0] = 5;
    run_merge_set(100);

    // unsorted stream: output follows the current heads only
    clear_streams();
    stream_len[0]    = 2;
    stream_val[0][0] = 3;
    stream_val[0][1] = 1;
    stream_len[1]    = 1;
    stream_val[1][0] = 2;
    run_merge_set(0);

    // every lane exhausted at load time gives the end marker at once
    write_lanes(1);
    clear_streams();
    run_merge_set(0);

    // above the lane count acts as all lanes
    write_lanes(4'hF);

    // random merge sets with occasional register changes
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 2) == 0) write_lanes(CFG_W'($urandom_range(0, 15)));
      src_no_idle = ($urandom_range(0, 3) == 0);
      fill_streams();
      run_merge_set(($urandom_range(0, 1) == 1) ? 20 : 0);
    end

    // drain the remaining results
    item_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_n != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_n == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/kwm_pkg.sv
rtl/core/kwm_if.sv
rtl/core/kwm_cell.sv
rtl/core/kwm_chain.sv
rtl/core/k_way_sorted_merge_unit.sv
tb/sv/kwm_merge_checker.sv
tb/sv/tb_top.sv
